>>> rtl/weighted_moving_average_top_macros.svh
// Assertion macros shared by the weighted moving average checker.
`ifndef WEIGHTED_MOVING_AVERAGE_TOP_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define WMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted moving average check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define WMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted moving average check failed");

`endif

>>> rtl/wma_pkg.sv
// Package with widths, constants and shared types of the weighted moving average.
package wma_pkg;

  localparam int WINDOW_DEF  = 8;
  localparam int NUM_WEIGHTS = 8;
  localparam int WIDX_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int CNT_W       = 4;
  localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;
  localparam int ACC_W       = PROD_W + 3;
  localparam int WSUM_W      = WEIGHT_W + 3;
  localparam int CFG_ADDR_W  = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int DIV_ITER    = ACC_W / 2;
  localparam int DIV_CNT_W   = 5;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  dividend;
    logic [WSUM_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/wma_store.sv
// Sample window memory with one write port and a registered read port.
module wma_store
  import wma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/wma_div.sv
// Signed by unsigned divider, two quotient bits per cycle, truncating toward zero.
module wma_div
  import wma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [WSUM_W:0]       rem_r;
  logic [WSUM_W:0]       rem_nxt;
  logic [ACC_W-1:0]      quo_r;
  logic [ACC_W-1:0]      quo_nxt;
  logic [WSUM_W-1:0]     dv_r;
  logic                  neg_r;
  logic [ACC_W-1:0]      mag;

  assign mag = req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < 2; k++) begin
      rem_nxt = {rem_nxt[WSUM_W-1:0], quo_nxt[ACC_W-1]};
      quo_nxt = {quo_nxt[ACC_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dv_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dv_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag;
      dv_r  <= req.divisor;
      neg_r <= req.dividend[ACC_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -quo_r[SAMPLE_W-1:0] : quo_r[SAMPLE_W-1:0];

endmodule

>>> rtl/weighted_moving_average_top.sv
// Weighted moving average: one sample in, one normalized weighted average out.
// Each accepted sample goes into a WINDOW-deep sample memory; the block then
// sweeps the samples in use, oldest first, through one registered multiplier
// and accumulator, and divides the sum by the weight sum in a divider that
// yields two quotient bits per cycle (a zero weight sum gives a zero average,
// flagged on out_tuser). The next sample is taken as soon as the result has
// moved to the output register, even while that result is still waiting to be
// taken.
module weighted_moving_average_top
  import wma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] average, [19:16] fill_count, zero pad
  output logic                   out_tuser,  // [0] zero_weight
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [WEIGHT_W-1:0]    cfg_wdata
);

  localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW1 = AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                 state_r;
  logic [WEIGHT_W-1:0]        weight_r [NUM_WEIGHTS];
  logic [AW-1:0]              wpos_r;
  logic [AW-1:0]              wpos_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic [CNT_W-1:0]           used_r;
  logic [AW-1:0]              start_r;
  logic [CNT_W-1:0]           idx_r;
  logic [AW1-1:0]             addr_sum;
  logic [AW-1:0]              rd_addr;
  logic                       issue;
  logic                       accept;
  logic                       rd_v_r;
  logic [WIDX_W-1:0]          widx_r;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       mul_v_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [WEIGHT_W-1:0]        mw_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [WSUM_W-1:0]          wsum_r;
  logic signed [SAMPLE_W-1:0] res_avg_r;
  logic                       res_zero_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_avg_r;
  logic [CNT_W-1:0]           out_cnt_r;
  logic                       out_zero_r;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic                       div_start_r;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign cnt_nxt  = (cnt_r == CNT_W'(WINDOW)) ? cnt_r : cnt_r + 1'b1;
  assign wpos_nxt = (wpos_r == AW'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;

  assign issue    = (state_r == S_MAC) && (idx_r != used_r);
  assign addr_sum = {1'b0, start_r} + {1'b0, idx_r[AW-1:0]};
  assign rd_addr  = (addr_sum >= AW1'(WINDOW)) ? AW'(addr_sum - AW1'(WINDOW)) : addr_sum[AW-1:0];

  wma_store #(.WINDOW(WINDOW), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wpos_r),
    .wr_data (in_tdata[SAMPLE_W-1:0]),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = acc_r;
  assign div_req.divisor  = wsum_r;

  wma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= WEIGHT_W'(1);
      end
    end else if (cfg_wr_en && (cfg_addr < CFG_ADDR_W'(NUM_WEIGHTS))) begin
      weight_r[cfg_addr[WIDX_W-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      rd_v_r      <= issue;
      mul_v_r     <= rd_v_r;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            wpos_r  <= wpos_nxt;
            cnt_r   <= cnt_nxt;
            idx_r   <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end else if (!rd_v_r && !mul_v_r) begin
            if (wsum_r == '0) begin
              state_r <= S_OUT;
            end else begin
              div_start_r <= 1'b1;
              state_r     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      used_r  <= cnt_nxt;
      start_r <= (cnt_nxt == CNT_W'(WINDOW)) ? wpos_nxt : '0;
      acc_r   <= '0;
      wsum_r  <= '0;
    end else if (mul_v_r) begin
      acc_r  <= acc_r + ACC_W'($signed(prod_r));
      wsum_r <= wsum_r + WSUM_W'(mw_r);
    end
    if (issue) begin
      widx_r <= idx_r[WIDX_W-1:0];
    end
    if (rd_v_r) begin
      prod_r <= $signed({1'b0, weight_r[widx_r]}) * rd_data;
      mw_r   <= weight_r[widx_r];
    end
    if ((state_r == S_MAC) && !issue && !rd_v_r && !mul_v_r && (wsum_r == '0)) begin
      res_avg_r  <= '0;
      res_zero_r <= 1'b1;
    end else if ((state_r == S_DIV) && div_rsp.done) begin
      res_avg_r  <= div_rsp.quotient;
      res_zero_r <= 1'b0;
    end
    if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
      out_avg_r  <= res_avg_r;
      out_cnt_r  <= used_r;
      out_zero_r <= res_zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - SAMPLE_W - CNT_W){1'b0}}, out_cnt_r, out_avg_r};
  assign out_tuser  = out_zero_r;

endmodule

>>> rtl/wma_checker.sv
// Port-level checker for the weighted moving average, bound to the top level.
`include "weighted_moving_average_top_macros.svh"

module wma_checker
  import wma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  `WMA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WMA_ASSERT_NOW(a_fill_range, out_tvalid, (out_tdata[19:16] != 4'd0) && (out_tdata[19:16] <= CNT_W'(WINDOW)))
  `WMA_ASSERT_NOW(a_zero_avg, out_tvalid && out_tuser, out_tdata[15:0] == 16'd0)
  `WMA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule

bind weighted_moving_average_top wma_checker #(.WINDOW(WINDOW)) u_wma_checker (.*);
